// ===== src/obbu_pkg.sv =====
// Shared constants, request codes and types of the oriented box bounds union core.
package obbu_pkg;

    localparam int Axes       = 3;
    localparam int EntryW     = 16;
    localparam int PosW       = 32;
    localparam int SizeW      = 31;
    localparam int RowW       = 3 * EntryW;
    localparam int ProdW      = EntryW + SizeW;
    localparam int SumW       = ProdW + 2;
    localparam int HalfShift  = 15;
    localparam int HwW        = SumW - HalfShift;
    localparam int WideW      = HwW + 2;
    localparam int QueueDepth = 4;

    localparam logic [1:0] KindAdd       = 2'd0;
    localparam logic [1:0] KindAddFinish = 2'd1;
    localparam logic [1:0] KindFinish    = 2'd2;

    localparam logic [PosW-1:0] BoundMax = {1'b0, {(PosW-1){1'b1}}};
    localparam logic [PosW-1:0] BoundMin = {1'b1, {(PosW-1){1'b0}}};

    typedef logic [Axes-1:0][PosW-1:0] t_axis_vec;

    typedef struct packed {
        logic      add;
        logic      finish;
        t_axis_vec lo;
        t_axis_vec hi;
    } t_box_bounds;

    function automatic logic [PosW-1:0] sat_bound(input logic [WideW-1:0] v);
        logic [WideW-PosW:0] top;
        top = v[WideW-1:PosW-1];
        if (top == '0 || top == '1) begin
            return v[PosW-1:0];
        end
        return v[WideW-1] ? BoundMin : BoundMax;
    endfunction

endpackage

// ===== src/obbu_if.sv =====
// Request and response channel interfaces of the oriented box bounds union core.
interface obbu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0] size_x;
    logic [30:0] size_y;
    logic [30:0] size_z;
    logic [47:0] rot_row0;
    logic [47:0] rot_row1;
    logic [47:0] rot_row2;

    modport source (
        output valid, kind, pos_x, pos_y, pos_z, size_x, size_y, size_z,
               rot_row0, rot_row1, rot_row2,
        input  ready
    );
    modport sink (
        input  valid, kind, pos_x, pos_y, pos_z, size_x, size_y, size_z,
               rot_row0, rot_row1, rot_row2,
        output ready
    );
endinterface

interface obbu_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0] extent_x;
    logic [31:0] extent_y;
    logic [31:0] extent_z;
    logic        is_empty;

    modport source (
        output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
               is_empty,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
               is_empty,
        output ready
    );
endinterface

// ===== src/obbu_front.sv =====
// Front pipeline: accept requests, decode kind, compute per-axis box bounds.
module obbu_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    obbu_req_if.sink             i_req,
    output obbu_pkg::t_box_bounds o_entry,
    output logic                 o_push,
    input  logic                 i_full
);

    localparam int Axes  = obbu_pkg::Axes;
    localparam int EntryW = obbu_pkg::EntryW;
    localparam int PosW  = obbu_pkg::PosW;
    localparam int SizeW = obbu_pkg::SizeW;
    localparam int RowW  = obbu_pkg::RowW;
    localparam int ProdW = obbu_pkg::ProdW;
    localparam int SumW  = obbu_pkg::SumW;
    localparam int HwW   = obbu_pkg::HwW;
    localparam int WideW = obbu_pkg::WideW;

    logic advance;
    logic accept;
    logic add_in;
    logic finish_in;

    logic [Axes-1:0][PosW-1:0]       pos_in;
    logic [2:0][SizeW-1:0]           size_in;
    logic [Axes-1:0][RowW-1:0]       row_in;
    logic [Axes-1:0][2:0][ProdW-1:0] prod;
    logic [Axes-1:0][HwW-1:0]        hw;
    obbu_pkg::t_axis_vec             lo_calc;
    obbu_pkg::t_axis_vec             hi_calc;

    logic                            r_s1_valid, r_s1_add, r_s1_finish;
    logic [Axes-1:0][PosW-1:0]       r_s1_pos;
    logic [Axes-1:0][2:0][ProdW-1:0] r_s1_prod;
    logic                            r_s2_valid, r_s2_add, r_s2_finish;
    logic [Axes-1:0][PosW-1:0]       r_s2_pos;
    logic [Axes-1:0][HwW-1:0]        r_s2_hw;
    logic                            r_s3_valid, r_s3_add, r_s3_finish;
    obbu_pkg::t_axis_vec             r_s3_lo;
    obbu_pkg::t_axis_vec             r_s3_hi;

    assign advance     = !r_s3_valid || !i_full;
    assign i_req.ready = advance;
    assign accept      = i_req.valid && advance;
    assign add_in      = (i_req.kind == obbu_pkg::KindAdd) ||
                         (i_req.kind == obbu_pkg::KindAddFinish);
    assign finish_in   = (i_req.kind != obbu_pkg::KindAdd);

    assign pos_in  = {i_req.pos_z, i_req.pos_y, i_req.pos_x};
    assign size_in = {i_req.size_z, i_req.size_y, i_req.size_x};
    assign row_in  = {i_req.rot_row2, i_req.rot_row1, i_req.rot_row0};

    always_comb begin
        logic [EntryW-1:0] ent;
        logic [EntryW-1:0] mag;
        for (int a = 0; a < Axes; a++) begin
            for (int c = 0; c < 3; c++) begin
                ent = row_in[a][c*EntryW +: EntryW];
                mag = ent[EntryW-1] ? EntryW'(-ent) : ent;
                prod[a][c] = ProdW'(mag) * ProdW'(size_in[c]);
            end
        end
    end

    always_comb begin
        logic [SumW-1:0] sum;
        for (int a = 0; a < Axes; a++) begin
            sum = SumW'(r_s1_prod[a][0]) + SumW'(r_s1_prod[a][1]) + SumW'(r_s1_prod[a][2]);
            hw[a] = sum[SumW-1:obbu_pkg::HalfShift];
        end
    end

    always_comb begin
        logic signed [WideW-1:0] pw;
        logic signed [WideW-1:0] hw_w;
        for (int a = 0; a < Axes; a++) begin
            pw = {{(WideW-PosW){r_s2_pos[a][PosW-1]}}, r_s2_pos[a]};
            hw_w = {{(WideW-HwW){1'b0}}, r_s2_hw[a]};
            lo_calc[a] = obbu_pkg::sat_bound(WideW'(pw - hw_w));
            hi_calc[a] = obbu_pkg::sat_bound(WideW'(pw + hw_w));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_add    <= add_in;
            r_s1_finish <= finish_in;
            r_s1_pos    <= pos_in;
            r_s1_prod   <= prod;
            r_s2_add    <= r_s1_add;
            r_s2_finish <= r_s1_finish;
            r_s2_pos    <= r_s1_pos;
            r_s2_hw     <= hw;
            r_s3_add    <= r_s2_add;
            r_s3_finish <= r_s2_finish;
            r_s3_lo     <= lo_calc;
            r_s3_hi     <= hi_calc;
        end
    end

    assign o_push         = r_s3_valid && !i_full;
    assign o_entry.add    = r_s3_add;
    assign o_entry.finish = r_s3_finish;
    assign o_entry.lo     = r_s3_lo;
    assign o_entry.hi     = r_s3_hi;

    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && i_full) |=> (r_s3_valid && $stable(r_s3_lo) && $stable(r_s3_hi)))
        else $error("front: stalled bounds changed");

endmodule

// ===== src/obbu_queue.sv =====
// Short queue of box bounds between the front pipeline and the accumulator.
module obbu_queue #(
    parameter int DEPTH = obbu_pkg::QueueDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  obbu_pkg::t_box_bounds i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output obbu_pkg::t_box_bounds o_entry,
    input  logic                  i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    obbu_pkg::t_box_bounds r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : PtrW'(p + 1'b1);
    endfunction

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = CntW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CntW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue: count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue: pointers differ while empty");

endmodule

// ===== src/obbu_back.sv =====
// Back end: merge bounds into running min/max, emit the union box on finish.
module obbu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  obbu_pkg::t_box_bounds i_entry,
    output logic                  o_pop,
    obbu_rsp_if.source            o_rsp
);

    localparam int Axes = obbu_pkg::Axes;
    localparam int PosW = obbu_pkg::PosW;
    localparam obbu_pkg::t_axis_vec IdleLo = {Axes{obbu_pkg::BoundMax}};
    localparam obbu_pkg::t_axis_vec IdleHi = {Axes{obbu_pkg::BoundMin}};

    obbu_pkg::t_axis_vec r_lo, n_lo;
    obbu_pkg::t_axis_vec r_hi, n_hi;
    logic                r_any, n_any;
    obbu_pkg::t_axis_vec r_res_lo, n_res_lo;
    obbu_pkg::t_axis_vec r_res_hi, n_res_hi;
    logic                r_res_empty, n_res_empty;
    logic                r_out_valid, n_out_valid;

    obbu_pkg::t_axis_vec m_lo;
    obbu_pkg::t_axis_vec m_hi;
    logic                m_any;
    obbu_pkg::t_axis_vec center;
    obbu_pkg::t_axis_vec extent;

    assign o_pop = i_valid && (!r_out_valid || o_rsp.ready);

    always_comb begin
        for (int a = 0; a < Axes; a++) begin
            m_lo[a] = (i_entry.add && ($signed(i_entry.lo[a]) < $signed(r_lo[a])))
                    ? i_entry.lo[a] : r_lo[a];
            m_hi[a] = (i_entry.add && ($signed(i_entry.hi[a]) > $signed(r_hi[a])))
                    ? i_entry.hi[a] : r_hi[a];
        end
        m_any = r_any || i_entry.add;
    end

    always_comb begin
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_any       = r_any;
        n_res_lo    = r_res_lo;
        n_res_hi    = r_res_hi;
        n_res_empty = r_res_empty;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (o_pop) begin
            if (i_entry.finish) begin
                n_lo        = IdleLo;
                n_hi        = IdleHi;
                n_any       = 1'b0;
                n_res_lo    = m_lo;
                n_res_hi    = m_hi;
                n_res_empty = !m_any;
                n_out_valid = 1'b1;
            end else begin
                n_lo  = m_lo;
                n_hi  = m_hi;
                n_any = m_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo        <= IdleLo;
            r_hi        <= IdleHi;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_any       <= n_any;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_lo    <= n_res_lo;
        r_res_hi    <= n_res_hi;
        r_res_empty <= n_res_empty;
    end

    always_comb begin
        logic [PosW:0] sum;
        for (int a = 0; a < Axes; a++) begin
            sum = {r_res_lo[a][PosW-1], r_res_lo[a]} + {r_res_hi[a][PosW-1], r_res_hi[a]};
            center[a] = r_res_empty ? '0 : sum[PosW:1];
            extent[a] = r_res_empty ? '0 : PosW'(r_res_hi[a] - r_res_lo[a]);
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.center_x = center[0];
    assign o_rsp.center_y = center[1];
    assign o_rsp.center_z = center[2];
    assign o_rsp.extent_x = extent[0];
    assign o_rsp.extent_y = extent[1];
    assign o_rsp.extent_z = extent[2];
    assign o_rsp.is_empty = r_res_empty;

    a_clear_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.finish) |=> (!r_any && r_out_valid))
        else $error("back: finish did not clear state or raise result");

    a_idle_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_lo == IdleLo && r_hi == IdleHi))
        else $error("back: bounds moved with no box seen");

endmodule

// ===== src/oriented_box_bounds_union_core.sv =====
// Top level of the oriented box bounds union core.
// Throughput: one request per cycle, sustained while results are taken.
// A finishing request's result is registered on its way out: products on acceptance,
// then the sum, saturate, queue and merge stages.
// Queue depth sets how long the front runs on while the result side stalls.
// Reset: synchronous active low; clears valids, queue and running bounds.
module oriented_box_bounds_union_core #(
    parameter int QUEUE_DEPTH = obbu_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    obbu_req_if.sink   i_req,
    obbu_rsp_if.source o_rsp
);

    obbu_pkg::t_box_bounds push_entry;
    obbu_pkg::t_box_bounds head_entry;
    logic                  push;
    logic                  full;
    logic                  head_valid;
    logic                  pop;

    obbu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_entry (push_entry),
        .o_push  (push),
        .i_full  (full)
    );

    obbu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (head_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    obbu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench of the oriented box bounds union core: streamed boxes, predicted unions.
module tb_top;

    localparam int Axes = obbu_pkg::Axes;
    localparam int EntryW = obbu_pkg::EntryW;
    localparam int PosW = obbu_pkg::PosW;
    localparam int SizeW = obbu_pkg::SizeW;
    localparam int RowW = obbu_pkg::RowW;
    localparam int HalfShift = obbu_pkg::HalfShift;
    localparam logic [1:0] KindAdd = obbu_pkg::KindAdd;
    localparam logic [1:0] KindAddFinish = obbu_pkg::KindAddFinish;
    localparam logic [1:0] KindFinish = obbu_pkg::KindFinish;
    localparam logic [PosW-1:0] BoundMax = obbu_pkg::BoundMax;
    localparam logic [PosW-1:0] BoundMin = obbu_pkg::BoundMin;

    localparam logic [1:0] KindSpare = 2'd3;
    localparam int ItemCount = 2000;
    localparam int CycleLimit = 400000;
    localparam int SettleCycles = 20;

    typedef struct packed {
        bit          drain_first;
        logic [1:0]  kind;
        obbu_pkg::t_axis_vec pos;
        logic [Axes-1:0][SizeW-1:0] size;
        logic [Axes-1:0][RowW-1:0]  rot;
    } t_box_req;

    typedef struct packed {
        obbu_pkg::t_axis_vec center;
        obbu_pkg::t_axis_vec extent;
        logic      is_empty;
    } t_union_bounds;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    obbu_req_if req_if ();
    obbu_rsp_if rsp_if ();

    oriented_box_bounds_union_core dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_box_req      box_queue[$];
    t_union_bounds bounds_due[$];
    t_box_req      held_req;

    logic signed [PosW-1:0] run_lo[Axes];
    logic signed [PosW-1:0] run_hi[Axes];
    bit run_any;

    int reqs_taken = 0;
    int boxes_added = 0;
    int unions_seen = 0;
    int empties_seen = 0;
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int mode_left = 0;
    int stall_mode = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_bounds();
        for (int a = 0; a < Axes; a++) begin
            run_lo[a] = BoundMax;
            run_hi[a] = BoundMin;
        end
        run_any = 1'b0;
    endfunction

    function automatic logic [PosW-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return BoundMax;
        if (v < -64'sd2147483648) return BoundMin;
        return v[PosW-1:0];
    endfunction

    function automatic void fold_box(input t_box_req r);
        longint unsigned mag;
        longint unsigned sum;
        longint hw;
        longint pos;
        longint mid;
        longint span;
        logic signed [PosW-1:0] lo;
        logic signed [PosW-1:0] hi;
        t_union_bounds res;
        if (r.kind == KindAdd || r.kind == KindAddFinish) begin
            for (int a = 0; a < Axes; a++) begin
                sum = 0;
                for (int c = 0; c < 3; c++) begin
                    mag = r.rot[a][c*EntryW +: EntryW];
                    if (mag[EntryW-1]) mag = 64'h10000 - mag;
                    sum += mag * r.size[c];
                end
                hw = longint'(sum >> HalfShift);
                pos = longint'($signed(r.pos[a]));
                lo = clamp32(pos - hw);
                hi = clamp32(pos + hw);
                if (lo < run_lo[a]) run_lo[a] = lo;
                if (hi > run_hi[a]) run_hi[a] = hi;
            end
            run_any = 1'b1;
            boxes_added++;
        end
        if (r.kind == KindAdd) return;
        res = '0;
        if (!run_any) begin
            res.is_empty = 1'b1;
        end else begin
            for (int a = 0; a < Axes; a++) begin
                mid = (longint'(run_lo[a]) + longint'(run_hi[a])) >>> 1;
                span = longint'(run_hi[a]) - longint'(run_lo[a]);
                res.center[a] = mid[PosW-1:0];
                res.extent[a] = span[PosW-1:0];
            end
        end
        bounds_due.push_back(res);
        clear_bounds();
    endfunction

    function automatic logic [EntryW-1:0] pick_entry(input bit wild);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'h4000;
            4: return 16'hC000;
            default: begin
                if (wild) return 16'($urandom);
                return 16'($urandom_range(0, 32768) - 16384);
            end
        endcase
    endfunction

    function automatic logic [PosW-1:0] pick_pos(input bit wild);
        case ($urandom_range(0, 9))
            0: return BoundMax;
            1: return BoundMin;
            2: return '0;
            default: begin
                if (wild) return $urandom;
                return 32'($urandom_range(0, 32'h2000000) - 32'h1000000);
            end
        endcase
    endfunction

    function automatic logic [SizeW-1:0] pick_size(input bit wild);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return {SizeW{1'b1}};
            default: begin
                if (wild) return SizeW'($urandom);
                return SizeW'($urandom_range(0, 32'h400000));
            end
        endcase
    endfunction

    function automatic t_box_req make_box(input logic [1:0] kind);
        t_box_req b;
        bit wild;
        wild = ($urandom_range(0, 7) == 0);
        b = '0;
        b.kind = kind;
        for (int a = 0; a < Axes; a++) begin
            b.pos[a] = pick_pos(wild);
            b.size[a] = pick_size(wild);
            for (int c = 0; c < 3; c++) begin
                b.rot[a][c*EntryW +: EntryW] = pick_entry(wild);
            end
        end
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [PosW-1:0] want,
                                        input logic [PosW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid    <= 1'b0;
            req_if.kind     <= KindAdd;
            req_if.pos_x    <= '0;
            req_if.pos_y    <= '0;
            req_if.pos_z    <= '0;
            req_if.size_x   <= '0;
            req_if.size_y   <= '0;
            req_if.size_z   <= '0;
            req_if.rot_row0 <= '0;
            req_if.rot_row1 <= '0;
            req_if.rot_row2 <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                fold_box(held_req);
                reqs_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (box_queue.size() == 0 ||
                             (box_queue[0].drain_first && bounds_due.size() != 0)) begin
                    req_if.valid <= 1'b0;
                end else begin
                    held_req = box_queue.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.kind     <= held_req.kind;
                    req_if.pos_x    <= held_req.pos[0];
                    req_if.pos_y    <= held_req.pos[1];
                    req_if.pos_z    <= held_req.pos[2];
                    req_if.size_x   <= held_req.size[0];
                    req_if.size_y   <= held_req.size[1];
                    req_if.size_z   <= held_req.size[2];
                    req_if.rot_row0 <= held_req.rot[0];
                    req_if.rot_row1 <= held_req.rot[1];
                    req_if.rot_row2 <= held_req.rot[2];
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // result stall pattern
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result monitor
    always @(posedge clk) begin
        t_union_bounds want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (bounds_due.size() == 0) begin
                $error("result with no request waiting for it");
                mismatches++;
            end else begin
                want = bounds_due.pop_front();
                check_field("center_x", want.center[0], rsp_if.center_x);
                check_field("center_y", want.center[1], rsp_if.center_y);
                check_field("center_z", want.center[2], rsp_if.center_z);
                check_field("extent_x", want.extent[0], rsp_if.extent_x);
                check_field("extent_y", want.extent[1], rsp_if.extent_y);
                check_field("extent_z", want.extent[2], rsp_if.extent_z);
                check_field("is_empty", PosW'(want.is_empty), PosW'(rsp_if.is_empty));
                if (want.is_empty) empties_seen++;
            end
            unions_seen++;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_box_req b;
        int made;
        int n;
        int first;
        bit drain;

        clear_bounds();

        // finish on an empty union, both finish codes
        box_queue.push_back(make_box(KindFinish));
        box_queue.push_back(make_box(KindSpare));

        // zero-size box at origin with identity rotation
        b = '0;
        b.kind = KindAddFinish;
        for (int a = 0; a < Axes; a++) b.rot[a][a*EntryW +: EntryW] = 16'h4000;
        box_queue.push_back(b);

        // saturate high and low bounds
        b.pos = {BoundMax, BoundMax, BoundMax};
        b.size = {Axes{{SizeW{1'b1}}}};
        b.rot = {Axes{48'h8000_8000_8000}};
        box_queue.push_back(b);
        b.pos = {BoundMin, BoundMin, BoundMin};
        b.size = {Axes{31'h0003_0000}};
        b.rot = {Axes{48'h7FFF_7FFF_7FFF}};
        box_queue.push_back(b);
        b.pos = '0;
        b.size = {Axes{{SizeW{1'b1}}}};
        b.rot = {48'hFFFF_0001_FFFF, 48'h0001_FFFF_0001, 48'hFFFF_FFFF_FFFF};
        box_queue.push_back(b);

        // distinct axes so every half-width and bound lands on its own axis
        b = '0;
        b.kind = KindAdd;
        b.pos = {32'hFFF8_0000, 32'hFFFC_0000, 32'hFFFE_0000};
        b.size = {31'h0003_0000, 31'h0002_0000, 31'h0001_0000};
        b.rot = {48'hC000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000};
        box_queue.push_back(b);
        b.pos = {32'h0005_8000, 32'h0003_0000, 32'h0001_8000};
        b.rot = {48'h2000_0000_1000, 48'h0000_E000_0000, 48'h0000_0000_C000};
        box_queue.push_back(b);
        b = make_box(KindSpare);
        box_queue.push_back(b);

        box_queue.push_back(make_box(KindAdd));
        box_queue.push_back(make_box(KindFinish));
        for (int k = 0; k < 6; k++) box_queue.push_back(make_box(KindAddFinish));
        box_queue.push_back(make_box(KindAdd));
        box_queue.push_back(make_box(KindAdd));
        box_queue.push_back(make_box(KindAddFinish));

        made = 0;
        drain = 1'b1;
        while (made < ItemCount) begin
            first = box_queue.size();
            if ($urandom_range(0, 9) == 0) begin
                box_queue.push_back(make_box(2'($urandom_range(0, 3))));
                made++;
            end else begin
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) box_queue.push_back(make_box(KindAdd));
                made += n;
                if (n > 0 && $urandom_range(0, 1) == 1) begin
                    box_queue[$].kind = KindAddFinish;
                end else begin
                    box_queue.push_back(make_box(($urandom_range(0, 4) == 0) ?
                                                 KindSpare : KindFinish));
                    made++;
                end
            end
            if (drain) box_queue[first].drain_first = 1'b1;
            drain = ($urandom_range(0, 199) == 0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (box_queue.size() != 0 || req_if.valid) @(posedge clk);
        while (bounds_due.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        $display("Sent %0d requests carrying %0d boxes over %0d cycles.",
                 reqs_taken, boxes_added, cycles);
        $display("Checked %0d union results, %0d of them empty.", unions_seen, empties_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/obbu_pkg.sv
src/obbu_if.sv
src/obbu_front.sv
src/obbu_queue.sv
src/obbu_back.sv
src/oriented_box_bounds_union_core.sv
sim/tb_top.sv
